// ===== hw/rtl/lsaf_pkg.sv =====
`default_nettype none

package lsaf_pkg;

  // Fixed field widths
  localparam int FIELD_W     = 16;
  localparam int COEF_W      = 32;
  localparam int COORD_MAX_W = 24;
  localparam int CFG_IDX_W   = 1;

  // Wide solver word: 8 limbs of 32 bits, arithmetic modulo 2^256
  localparam int WIDE_W     = 256;
  localparam int LIMB_W     = 32;
  localparam int N_LIMBS    = 8;
  localparam int LIMB_IDX_W = 3;
  localparam int DIV_CNT_W  = 8;

  // Solver register file and program
  localparam int RF_DEPTH = 21;
  localparam int RF_AW    = 5;
  localparam int PC_W     = 7;
  localparam int N_COEF   = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

  typedef logic [RF_AW-1:0] rf_addr_t;

  typedef enum logic [3:0] {
    OP_LOAD, OP_MUL, OP_ADD, OP_SUB, OP_SHL16, OP_SHL12, OP_TSTZ, OP_DIV, OP_END
  } op_e;

  typedef struct packed {
    op_e      op;
    rf_addr_t dst;
    rf_addr_t a;
    rf_addr_t b;
  } instr_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] src_x;
    logic signed [FIELD_W-1:0] src_y;
    logic signed [FIELD_W-1:0] dst_x;
    logic signed [FIELD_W-1:0] dst_y;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] x_from_x;
    logic signed [COEF_W-1:0] x_from_y;
    logic signed [COEF_W-1:0] x_offset;
    logic signed [COEF_W-1:0] y_from_x;
    logic signed [COEF_W-1:0] y_from_y;
    logic signed [COEF_W-1:0] y_offset;
    logic                     singular;
    logic                     overflowed;
  } fit_t;

  typedef struct packed {
    logic   go;
    instr_t ins;
    logic   pub;
    logic   sing;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic det_zero;
    logic few_points;
    logic pipe_busy;
    logic out_free;
    logic busy;
  } dp_stat_t;

  // Register file map: loaded sums first, then cofactors and scratch
  localparam rf_addr_t R_M00 = 5'd0;   // sum_xx
  localparam rf_addr_t R_M01 = 5'd1;   // sum_xy
  localparam rf_addr_t R_M02 = 5'd2;   // sum_sx
  localparam rf_addr_t R_M11 = 5'd3;   // sum_yy
  localparam rf_addr_t R_M12 = 5'd4;   // sum_sy
  localparam rf_addr_t R_M22 = 5'd5;   // point count
  localparam rf_addr_t R_XU  = 5'd6;
  localparam rf_addr_t R_YU  = 5'd7;
  localparam rf_addr_t R_U   = 5'd8;
  localparam rf_addr_t R_XV  = 5'd9;
  localparam rf_addr_t R_YV  = 5'd10;
  localparam rf_addr_t R_V   = 5'd11;
  localparam rf_addr_t R_C00 = 5'd12;
  localparam rf_addr_t R_C01 = 5'd13;
  localparam rf_addr_t R_C02 = 5'd14;
  localparam rf_addr_t R_C11 = 5'd15;
  localparam rf_addr_t R_C12 = 5'd16;
  localparam rf_addr_t R_C22 = 5'd17;
  localparam rf_addr_t R_DET = 5'd18;
  localparam rf_addr_t R_T0  = 5'd19;
  localparam rf_addr_t R_T1  = 5'd20;

  // Coefficient slots, used as destination of a divide
  localparam rf_addr_t K_X_FROM_X = 5'd0;
  localparam rf_addr_t K_X_FROM_Y = 5'd1;
  localparam rf_addr_t K_X_OFFSET = 5'd2;
  localparam rf_addr_t K_Y_FROM_X = 5'd3;
  localparam rf_addr_t K_Y_FROM_Y = 5'd4;
  localparam rf_addr_t K_Y_OFFSET = 5'd5;

  function automatic instr_t mk(op_e op, rf_addr_t d, rf_addr_t a, rf_addr_t b);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.a   = a;
    i.b   = b;
    return i;
  endfunction

  // Solve program: loads, cofactors, determinant and its zero test, then Cramer numerators and divides
  function automatic instr_t prog_rom(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      7'd0:  i = mk(OP_LOAD, R_M00, R_M00, R_M00);
      7'd1:  i = mk(OP_LOAD, R_M01, R_M01, R_M01);
      7'd2:  i = mk(OP_LOAD, R_M02, R_M02, R_M02);
      7'd3:  i = mk(OP_LOAD, R_M11, R_M11, R_M11);
      7'd4:  i = mk(OP_LOAD, R_M12, R_M12, R_M12);
      7'd5:  i = mk(OP_LOAD, R_M22, R_M22, R_M22);
      7'd6:  i = mk(OP_LOAD, R_XU, R_XU, R_XU);
      7'd7:  i = mk(OP_LOAD, R_YU, R_YU, R_YU);
      7'd8:  i = mk(OP_LOAD, R_U, R_U, R_U);
      7'd9:  i = mk(OP_LOAD, R_XV, R_XV, R_XV);
      7'd10: i = mk(OP_LOAD, R_YV, R_YV, R_YV);
      7'd11: i = mk(OP_LOAD, R_V, R_V, R_V);
      7'd12: i = mk(OP_MUL, R_T0, R_M11, R_M22);
      7'd13: i = mk(OP_MUL, R_T1, R_M12, R_M12);
      7'd14: i = mk(OP_SUB, R_C00, R_T0, R_T1);
      7'd15: i = mk(OP_MUL, R_T0, R_M12, R_M02);
      7'd16: i = mk(OP_MUL, R_T1, R_M01, R_M22);
      7'd17: i = mk(OP_SUB, R_C01, R_T0, R_T1);
      7'd18: i = mk(OP_MUL, R_T0, R_M01, R_M12);
      7'd19: i = mk(OP_MUL, R_T1, R_M11, R_M02);
      7'd20: i = mk(OP_SUB, R_C02, R_T0, R_T1);
      7'd21: i = mk(OP_MUL, R_T0, R_M00, R_M22);
      7'd22: i = mk(OP_MUL, R_T1, R_M02, R_M02);
      7'd23: i = mk(OP_SUB, R_C11, R_T0, R_T1);
      7'd24: i = mk(OP_MUL, R_T0, R_M01, R_M02);
      7'd25: i = mk(OP_MUL, R_T1, R_M00, R_M12);
      7'd26: i = mk(OP_SUB, R_C12, R_T0, R_T1);
      7'd27: i = mk(OP_MUL, R_T0, R_M00, R_M11);
      7'd28: i = mk(OP_MUL, R_T1, R_M01, R_M01);
      7'd29: i = mk(OP_SUB, R_C22, R_T0, R_T1);
      7'd30: i = mk(OP_MUL, R_T0, R_M00, R_C00);
      7'd31: i = mk(OP_MUL, R_T1, R_M01, R_C01);
      7'd32: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd33: i = mk(OP_MUL, R_T1, R_M02, R_C02);
      7'd34: i = mk(OP_ADD, R_DET, R_T0, R_T1);
      7'd35: i = mk(OP_TSTZ, R_DET, R_DET, R_DET);
      // x row
      7'd36: i = mk(OP_MUL, R_T0, R_C00, R_XU);
      7'd37: i = mk(OP_MUL, R_T1, R_C01, R_YU);
      7'd38: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd39: i = mk(OP_MUL, R_T1, R_C02, R_U);
      7'd40: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd41: i = mk(OP_SHL16, R_T0, R_T0, R_T0);
      7'd42: i = mk(OP_DIV, K_X_FROM_X, R_T0, R_DET);
      7'd43: i = mk(OP_MUL, R_T0, R_C01, R_XU);
      7'd44: i = mk(OP_MUL, R_T1, R_C11, R_YU);
      7'd45: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd46: i = mk(OP_MUL, R_T1, R_C12, R_U);
      7'd47: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd48: i = mk(OP_SHL16, R_T0, R_T0, R_T0);
      7'd49: i = mk(OP_DIV, K_X_FROM_Y, R_T0, R_DET);
      7'd50: i = mk(OP_MUL, R_T0, R_C02, R_XU);
      7'd51: i = mk(OP_MUL, R_T1, R_C12, R_YU);
      7'd52: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd53: i = mk(OP_MUL, R_T1, R_C22, R_U);
      7'd54: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd55: i = mk(OP_SHL12, R_T0, R_T0, R_T0);
      7'd56: i = mk(OP_DIV, K_X_OFFSET, R_T0, R_DET);
      // y row
      7'd57: i = mk(OP_MUL, R_T0, R_C00, R_XV);
      7'd58: i = mk(OP_MUL, R_T1, R_C01, R_YV);
      7'd59: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd60: i = mk(OP_MUL, R_T1, R_C02, R_V);
      7'd61: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd62: i = mk(OP_SHL16, R_T0, R_T0, R_T0);
      7'd63: i = mk(OP_DIV, K_Y_FROM_X, R_T0, R_DET);
      7'd64: i = mk(OP_MUL, R_T0, R_C01, R_XV);
      7'd65: i = mk(OP_MUL, R_T1, R_C11, R_YV);
      7'd66: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd67: i = mk(OP_MUL, R_T1, R_C12, R_V);
      7'd68: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd69: i = mk(OP_SHL16, R_T0, R_T0, R_T0);
      7'd70: i = mk(OP_DIV, K_Y_FROM_Y, R_T0, R_DET);
      7'd71: i = mk(OP_MUL, R_T0, R_C02, R_XV);
      7'd72: i = mk(OP_MUL, R_T1, R_C12, R_YV);
      7'd73: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd74: i = mk(OP_MUL, R_T1, R_C22, R_V);
      7'd75: i = mk(OP_ADD, R_T0, R_T0, R_T1);
      7'd76: i = mk(OP_SHL12, R_T0, R_T0, R_T0);
      7'd77: i = mk(OP_DIV, K_Y_OFFSET, R_T0, R_DET);
      default: i = mk(OP_END, R_T0, R_T0, R_T0);
    endcase
    return i;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lsaf_controller.sv =====
`default_nettype none

module lsaf_controller
  import lsaf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_last_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_ACC, S_DRAIN, S_ISSUE, S_WAIT, S_PUB
  } state_e;

  state_e          state_q;
  logic [PC_W-1:0] pc_q;
  logic            sing_q;
  instr_t          ins;

  // Command decode
  always_comb begin
    ins         = prog_rom(pc_q);
    cmd_o.go    = (state_q == S_ISSUE) && (ins.op != OP_END);
    cmd_o.ins   = ins;
    cmd_o.pub   = (state_q == S_PUB) && stat_i.out_free;
    cmd_o.sing  = sing_q;
    in_ready_o  = (state_q == S_ACC);
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      pc_q    <= '0;
      sing_q  <= 1'b0;
    end else begin
      case (state_q)
        S_ACC: begin
          if (in_valid_i && in_last_i) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          // let the accumulation pipe settle
          if (!stat_i.pipe_busy) begin
            if (stat_i.few_points) begin
              sing_q  <= 1'b1;
              state_q <= S_PUB;
            end else begin
              sing_q  <= 1'b0;
              pc_q    <= '0;
              state_q <= S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (ins.op == OP_END) state_q <= S_PUB;
          else state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (stat_i.done) begin
            if ((ins.op == OP_TSTZ) && stat_i.det_zero) begin
              sing_q  <= 1'b1;
              state_q <= S_PUB;
            end else begin
              pc_q    <= pc_q + 1'b1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_PUB: begin
          if (stat_i.out_free) state_q <= S_ACC;
        end
        default: state_q <= S_ACC;
      endcase
    end
  end

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.go |-> !stat_i.busy) else $error("command issued while datapath busy");
  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pub |-> stat_i.out_free) else $error("publish into occupied output");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.done |-> (state_q == S_WAIT)) else $error("unexpected done");

endmodule

`default_nettype wire

// ===== hw/rtl/lsaf_datapath.sv =====
`default_nettype none

module lsaf_datapath
  import lsaf_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FIELD_W-1:0]   cfg_wdata_i,
  input  wire logic                 in_accept_i,
  input  wire point_t               in_data_i,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output fit_t                      out_data_o
);

  localparam int D_W   = COORD_BITS + 1;
  localparam int P_W   = 2 * D_W;
  localparam int LOG_N = $clog2(MAX_POINTS);
  localparam int SQ_W  = (P_W + LOG_N > 64) ? 64 : P_W + LOG_N;
  localparam int LIN_W = (D_W + LOG_N > 64) ? 64 : D_W + LOG_N;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {DV_ABS, DV_PREP, DV_ITER, DV_SAT} dv_ph_e;

  function automatic logic signed [D_W-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic [COORD_MAX_W-1:0] z;
    z = COORD_MAX_W'(f);
    return D_W'($signed(z[COORD_BITS-1:0]));
  endfunction

  // Origin registers
  logic [FIELD_W-1:0] org_x_q, org_y_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ORIGIN_X) org_x_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_ORIGIN_Y) org_y_q <= cfg_wdata_i;
    end
  end

  // Point count and overflow
  logic [CNT_W-1:0] count_q;
  logic             ovf_q;
  logic             take;
  assign take = in_accept_i && (count_q < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (cmd_i.pub) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (in_accept_i) begin
      if (take) count_q <= count_q + 1'b1;
      else ovf_q <= 1'b1;
    end
  end

  // Accumulation pipe: shift, multiply, accumulate
  logic                    s1_v_q, s2_v_q;
  logic signed [D_W-1:0]   x1_q, y1_q, u1_q, v1_q, x2_q, y2_q, u2_q, v2_q;
  logic signed [P_W-1:0]   pxx_q, pxy_q, pyy_q, pxu_q, pyu_q, pxv_q, pyv_q;
  logic signed [SQ_W-1:0]  sxx_q, sxy_q, syy_q, sxu_q, syu_q, sxv_q, syv_q;
  logic signed [LIN_W-1:0] sx_q, sy_q, su_q, sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= take;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x1_q <= to_coord(in_data_i.src_x) - to_coord(org_x_q);
      y1_q <= to_coord(in_data_i.src_y) - to_coord(org_y_q);
      u1_q <= to_coord(in_data_i.dst_x) - to_coord(org_x_q);
      v1_q <= to_coord(in_data_i.dst_y) - to_coord(org_y_q);
    end
    pxx_q <= x1_q * x1_q;
    pxy_q <= x1_q * y1_q;
    pyy_q <= y1_q * y1_q;
    pxu_q <= x1_q * u1_q;
    pyu_q <= y1_q * u1_q;
    pxv_q <= x1_q * v1_q;
    pyv_q <= y1_q * v1_q;
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    u2_q  <= u1_q;
    v2_q  <= v1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sxx_q <= '0; sxy_q <= '0; syy_q <= '0; sxu_q <= '0; syu_q <= '0;
      sxv_q <= '0; syv_q <= '0; sx_q <= '0; sy_q <= '0; su_q <= '0; sv_q <= '0;
    end else if (cmd_i.pub) begin
      sxx_q <= '0; sxy_q <= '0; syy_q <= '0; sxu_q <= '0; syu_q <= '0;
      sxv_q <= '0; syv_q <= '0; sx_q <= '0; sy_q <= '0; su_q <= '0; sv_q <= '0;
    end else if (s2_v_q) begin
      sxx_q <= sxx_q + SQ_W'(pxx_q);
      sxy_q <= sxy_q + SQ_W'(pxy_q);
      syy_q <= syy_q + SQ_W'(pyy_q);
      sxu_q <= sxu_q + SQ_W'(pxu_q);
      syu_q <= syu_q + SQ_W'(pyu_q);
      sxv_q <= sxv_q + SQ_W'(pxv_q);
      syv_q <= syv_q + SQ_W'(pyv_q);
      sx_q  <= sx_q + LIN_W'(x2_q);
      sy_q  <= sy_q + LIN_W'(y2_q);
      su_q  <= su_q + LIN_W'(u2_q);
      sv_q  <= sv_q + LIN_W'(v2_q);
    end
  end

  // Solver register file, registered reads
  logic [WIDE_W-1:0] rf_mem [RF_DEPTH];
  logic [WIDE_W-1:0] opa_q, opb_q;
  logic              rf_we;
  logic [WIDE_W-1:0] rf_wdata;

  logic     run_q;
  op_e      op_q;
  rf_addr_t dst_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      opa_q <= rf_mem[cmd_i.ins.a];
      opb_q <= rf_mem[cmd_i.ins.b];
    end
    if (rf_we) rf_mem[dst_q] <= rf_wdata;
  end

  // Sum selected for a load
  logic [WIDE_W-1:0] load_val;
  always_comb begin
    case (dst_q)
      R_M00:   load_val = WIDE_W'(sxx_q);
      R_M01:   load_val = WIDE_W'(sxy_q);
      R_M02:   load_val = WIDE_W'(sx_q);
      R_M11:   load_val = WIDE_W'(syy_q);
      R_M12:   load_val = WIDE_W'(sy_q);
      R_M22:   load_val = WIDE_W'(count_q);
      R_XU:    load_val = WIDE_W'(sxu_q);
      R_YU:    load_val = WIDE_W'(syu_q);
      R_U:     load_val = WIDE_W'(su_q);
      R_XV:    load_val = WIDE_W'(sxv_q);
      R_YV:    load_val = WIDE_W'(syv_q);
      R_V:     load_val = WIDE_W'(sv_q);
      default: load_val = '0;
    endcase
  end

  // Limb-serial multiplier state
  logic [LIMB_IDX_W-1:0] mi_q, mj_q, sh_q;
  logic                  mul_iss_q, pv_q;
  logic [2*LIMB_W-1:0]   prod_q;
  logic [WIDE_W-1:0]     acc_q, acc_nx;
  logic                  pair_end;

  assign acc_nx   = acc_q + (WIDE_W'(prod_q) << {sh_q, 5'b0});
  assign pair_end = ({1'b0, mi_q} + {1'b0, mj_q}) == (LIMB_IDX_W + 1)'(N_LIMBS - 1);

  // Restoring divider state
  dv_ph_e               dv_ph_q;
  logic [DIV_CNT_W-1:0] dv_cnt_q;
  logic                 dv_neg_q;
  logic [WIDE_W-1:0]    dv_n_q, dv_d_q, dv_r_q, dv_qt_q, dv_rsh;
  logic [COEF_W-1:0]    dv_res;

  assign dv_rsh = {dv_r_q[WIDE_W-2:0], dv_n_q[WIDE_W-1]};

  // Round-to-nearest quotient saturated to 32 bits
  always_comb begin
    if (|dv_qt_q[WIDE_W-1:COEF_W]) begin
      dv_res = dv_neg_q ? {1'b1, {(COEF_W-1){1'b0}}} : {1'b0, {(COEF_W-1){1'b1}}};
    end else if (dv_neg_q) begin
      dv_res = dv_qt_q[COEF_W-1] ? {1'b1, {(COEF_W-1){1'b0}}} : -dv_qt_q[COEF_W-1:0];
    end else begin
      dv_res = dv_qt_q[COEF_W-1] ? {1'b0, {(COEF_W-1){1'b1}}} : dv_qt_q[COEF_W-1:0];
    end
  end

  // Completion and write-back
  logic done;
  always_comb begin
    case (op_q)
      OP_MUL:  done = run_q && !mul_iss_q && pv_q;
      OP_DIV:  done = run_q && (dv_ph_q == DV_SAT);
      default: done = run_q;
    endcase
    rf_we = done && (op_q != OP_TSTZ) && (op_q != OP_DIV);
    case (op_q)
      OP_LOAD:  rf_wdata = load_val;
      OP_MUL:   rf_wdata = acc_nx;
      OP_ADD:   rf_wdata = opa_q + opb_q;
      OP_SUB:   rf_wdata = opa_q - opb_q;
      OP_SHL16: rf_wdata = opa_q << 16;
      OP_SHL12: rf_wdata = opa_q << 12;
      default:  rf_wdata = opa_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      op_q      <= OP_END;
      dst_q     <= '0;
      mul_iss_q <= 1'b0;
      pv_q      <= 1'b0;
      dv_ph_q   <= DV_ABS;
    end else if (cmd_i.go) begin
      run_q     <= 1'b1;
      op_q      <= cmd_i.ins.op;
      dst_q     <= cmd_i.ins.dst;
      mul_iss_q <= 1'b1;
      pv_q      <= 1'b0;
      dv_ph_q   <= DV_ABS;
    end else if (run_q) begin
      if (done) run_q <= 1'b0;
      if (op_q == OP_MUL) begin
        pv_q <= mul_iss_q;
        if (mul_iss_q && pair_end && (mj_q == LIMB_IDX_W'(N_LIMBS - 1))) mul_iss_q <= 1'b0;
      end
      if (op_q == OP_DIV) begin
        case (dv_ph_q)
          DV_ABS:  dv_ph_q <= DV_PREP;
          DV_PREP: dv_ph_q <= DV_ITER;
          DV_ITER: if (dv_cnt_q == '1) dv_ph_q <= DV_SAT;
          default: dv_ph_q <= DV_ABS;
        endcase
      end
    end
  end

  // Multiplier and divider datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.go) begin
      mi_q  <= '0;
      mj_q  <= '0;
      acc_q <= '0;
    end else if (run_q && (op_q == OP_MUL)) begin
      if (mul_iss_q) begin
        prod_q <= opa_q[mi_q*LIMB_W +: LIMB_W] * opb_q[mj_q*LIMB_W +: LIMB_W];
        sh_q   <= mi_q + mj_q;
        if (pair_end) begin
          mi_q <= '0;
          mj_q <= mj_q + 1'b1;
        end else begin
          mi_q <= mi_q + 1'b1;
        end
      end
      if (pv_q) acc_q <= acc_nx;
    end
    if (run_q && (op_q == OP_DIV)) begin
      case (dv_ph_q)
        DV_ABS: begin
          dv_neg_q <= opa_q[WIDE_W-1] ^ opb_q[WIDE_W-1];
          dv_n_q   <= opa_q[WIDE_W-1] ? -opa_q : opa_q;
          dv_d_q   <= opb_q[WIDE_W-1] ? -opb_q : opb_q;
        end
        DV_PREP: begin
          dv_n_q   <= (dv_n_q << 1) + dv_d_q;
          dv_d_q   <= dv_d_q << 1;
          dv_r_q   <= '0;
          dv_qt_q  <= '0;
          dv_cnt_q <= '0;
        end
        DV_ITER: begin
          dv_n_q   <= dv_n_q << 1;
          dv_cnt_q <= dv_cnt_q + 1'b1;
          if (dv_rsh >= dv_d_q) begin
            dv_r_q  <= dv_rsh - dv_d_q;
            dv_qt_q <= {dv_qt_q[WIDE_W-2:0], 1'b1};
          end else begin
            dv_r_q  <= dv_rsh;
            dv_qt_q <= {dv_qt_q[WIDE_W-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
  end

  // Coefficient slots
  logic [COEF_W-1:0] coef_q [N_COEF];
  always_ff @(posedge clk_i) begin
    if (done && (op_q == OP_DIV)) coef_q[dst_q[2:0]] <= dv_res;
  end

  // Output register
  logic out_valid_q;
  fit_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.pub) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pub) begin
      out_q.x_from_x   <= cmd_i.sing ? '0 : coef_q[0];
      out_q.x_from_y   <= cmd_i.sing ? '0 : coef_q[1];
      out_q.x_offset   <= cmd_i.sing ? '0 : coef_q[2];
      out_q.y_from_x   <= cmd_i.sing ? '0 : coef_q[3];
      out_q.y_from_y   <= cmd_i.sing ? '0 : coef_q[4];
      out_q.y_offset   <= cmd_i.sing ? '0 : coef_q[5];
      out_q.singular   <= cmd_i.sing;
      out_q.overflowed <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the controller
  always_comb begin
    stat_o.done       = done;
    stat_o.det_zero   = (opa_q == '0);
    stat_o.few_points = (count_q < CNT_W'(3));
    stat_o.pipe_busy  = s1_v_q || s2_v_q;
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.busy       = run_q;
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_POINTS)) else $error("point count beyond limit");
  a_pub_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pub |=> (count_q == '0) && !ovf_q) else $error("sums not cleared");
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !cmd_i.go |=> !run_q) else $error("unit still running after done");

endmodule

`default_nettype wire

// ===== hw/rtl/least_squares_affine_fit_unit.sv =====
// Points: one beat per cycle, three-stage accumulate pipe (shift, multiply, add).
// The solve after the last point is set by the 256-bit limb-serial multiplier
// (33 products) and the bit-serial divider (six coefficients); singular sets end early.
// The input stalls during a solve; a result may wait while the next set streams in.
// Reset (rst_ni low, asynchronous) clears origins, sums, count and flags.
`default_nettype none

module least_squares_affine_fit_unit
  import lsaf_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int COORD_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [FIELD_W-1:0]   cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire point_t               in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output fit_t                      out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  lsaf_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_point),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lsaf_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_accept_i (in_accept),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
  import lsaf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PTS      = 4096;
  localparam int STALL_LIMIT  = 20000;
  localparam int SETTLE_CYCLES = 50;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_ORIGIN_X;
  logic [FIELD_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  point_t               in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  fit_t                 out_data_o;

  least_squares_affine_fit_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: origins and normal-equation sums
  logic signed [FIELD_W-1:0] org_x, org_y;
  logic [63:0] acc_xx, acc_xy, acc_yy, acc_x, acc_y;
  logic [63:0] acc_xu, acc_yu, acc_u, acc_xv, acc_yv, acc_v;
  int unsigned n_pts;
  bit          pts_dropped;

  fit_t fit_queue[$];
  int   errors, n_beats, n_fits, n_singular, n_ovf;
  bit   calm;       // no idling on either side
  int   stall_cnt;
  int   rx_hold = 0;

  function automatic void clear_acc();
    {acc_xx, acc_xy, acc_yy, acc_x, acc_y} = '0;
    {acc_xu, acc_yu, acc_u, acc_xv, acc_yv, acc_v} = '0;
    n_pts = 0;
    pts_dropped = 1'b0;
  endfunction

  function automatic logic signed [255:0] widen(logic [63:0] v);
    return {{192{v[63]}}, v};
  endfunction

  // round to nearest, ties away from zero, saturated to 32 bits
  function automatic logic [31:0] round_div(logic signed [255:0] num,
                                            logic signed [255:0] den);
    logic        neg;
    logic [255:0] an, ad, q;
    neg = num[255] ^ den[255];
    an  = num[255] ? -num : num;
    ad  = den[255] ? -den : den;
    q   = ((an << 1) + ad) / (ad << 1);
    if (q[255:32] != '0) return neg ? 32'h8000_0000 : 32'h7fff_ffff;
    if (neg) return q[31] ? 32'h8000_0000 : -q[31:0];
    return q[31] ? 32'h7fff_ffff : q[31:0];
  endfunction

  function automatic fit_t solve_fit();
    fit_t f;
    logic signed [255:0] m00, m01, m02, m11, m12, m22;
    logic signed [255:0] c00, c01, c02, c11, c12, c22, det, r0, r1, r2;
    logic [31:0] co[6];
    f = '0;
    f.overflowed = pts_dropped;
    f.singular = n_pts < 3;
    if (f.singular) return f;
    m00 = widen(acc_xx); m01 = widen(acc_xy); m02 = widen(acc_x);
    m11 = widen(acc_yy); m12 = widen(acc_y);  m22 = 256'(n_pts);
    c00 = m11 * m22 - m12 * m12;
    c01 = m12 * m02 - m01 * m22;
    c02 = m01 * m12 - m11 * m02;
    c11 = m00 * m22 - m02 * m02;
    c12 = m01 * m02 - m00 * m12;
    c22 = m00 * m11 - m01 * m01;
    det = m00 * c00 + m01 * c01 + m02 * c02;
    if (det == 0) begin
      f.singular = 1'b1;
      return f;
    end
    for (int i = 0; i < 2; i++) begin
      r0 = widen(i ? acc_xv : acc_xu);
      r1 = widen(i ? acc_yv : acc_yu);
      r2 = widen(i ? acc_v : acc_u);
      co[i*3]   = round_div((c00 * r0 + c01 * r1 + c02 * r2) * 65536, det);
      co[i*3+1] = round_div((c01 * r0 + c11 * r1 + c12 * r2) * 65536, det);
      co[i*3+2] = round_div((c02 * r0 + c12 * r1 + c22 * r2) * 4096, det);
    end
    f.x_from_x = co[0]; f.x_from_y = co[1]; f.x_offset = co[2];
    f.y_from_x = co[3]; f.y_from_y = co[4]; f.y_offset = co[5];
    return f;
  endfunction

  // Update sums with one accepted point; queue a fit on the last one
  function automatic void accumulate(point_t p);
    logic signed [63:0] x, y, u, v;
    if (n_pts >= MAX_PTS) begin
      pts_dropped = 1'b1;
    end else begin
      x = 64'(p.src_x) - 64'(org_x);
      y = 64'(p.src_y) - 64'(org_y);
      u = 64'(p.dst_x) - 64'(org_x);
      v = 64'(p.dst_y) - 64'(org_y);
      acc_xx += x * x; acc_xy += x * y; acc_yy += y * y;
      acc_x  += x;     acc_y  += y;
      acc_xu += x * u; acc_yu += y * u; acc_u += u;
      acc_xv += x * v; acc_yv += y * v; acc_v += v;
      n_pts++;
    end
    if (p.last_point) begin
      fit_queue.push_back(solve_fit());
      clear_acc();
    end
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Called at a falling edge; returns at a falling edge with valid still high
  task automatic send_point(point_t p);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    n_beats++;
    accumulate(p);
    @(negedge clk_i);
  endtask

  // Sender holds off until every queued fit has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (fit_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_origin(logic [CFG_IDX_W-1:0] idx, logic signed [FIELD_W-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ORIGIN_X) org_x = val;
    else org_y = val;
  endtask

  function automatic point_t mk_point(int sx, int sy, int dx, int dy, bit lst);
    point_t p;
    p.src_x = FIELD_W'(sx); p.src_y = FIELD_W'(sy);
    p.dst_x = FIELD_W'(dx); p.dst_y = FIELD_W'(dy);
    p.last_point = lst;
    return p;
  endfunction

  function automatic point_t rand_point(bit lst);
    point_t p;
    p = point_t'({$urandom, $urandom, 1'b0});
    p.last_point = lst;
    return p;
  endfunction

  // One set drawn from an affine map with a little noise
  task automatic send_mapped_set(int len);
    int a, b, c, d, e, f, sx, sy;
    a = $urandom_range(0, 64) - 32; b = $urandom_range(0, 64) - 32;
    d = $urandom_range(0, 64) - 32; e = $urandom_range(0, 64) - 32;
    c = $urandom_range(0, 8000) - 4000; f = $urandom_range(0, 8000) - 4000;
    for (int i = 0; i < len; i++) begin
      sx = $urandom_range(0, 4000) - 2000;
      sy = $urandom_range(0, 4000) - 2000;
      send_point(mk_point(sx, sy,
                          (a * sx + b * sy) / 16 + c + $urandom_range(0, 6) - 3,
                          (d * sx + e * sy) / 16 + f + $urandom_range(0, 6) - 3,
                          i == len - 1));
    end
  endtask

  // Too few points, collinear and repeated points
  task automatic test_singular_sets();
    send_point(mk_point(100, 200, 300, 400, 1'b1));
    send_point(mk_point(-5, 7, 1, 2, 1'b0));
    send_point(mk_point(9, -3, 4, 4, 1'b1));
    for (int i = 0; i < 4; i++) send_point(mk_point(16 * i, 32 * i, i, -i, i == 3));
    for (int i = 0; i < 3; i++) send_point(mk_point(-7, 11, 5, 5, i == 2));
  endtask

  // Field extremes, exact fit, and a set with steep slopes that saturates
  task automatic test_extreme_points();
    send_point(mk_point(-32768, -32768, 32767, 32767, 1'b0));
    send_point(mk_point(32767, -32768, -32768, 32767, 1'b0));
    send_point(mk_point(-32768, 32767, 32767, -32768, 1'b0));
    send_point(mk_point(32767, 32767, -32768, -32768, 1'b1));
    send_point(mk_point(0, 0, 16, 32, 1'b0));
    send_point(mk_point(16, 0, 48, 32, 1'b0));
    send_point(mk_point(0, 16, 16, 80, 1'b1));
    send_point(mk_point(0, 0, -32768, 32767, 1'b0));
    send_point(mk_point(1, 0, 32767, -32768, 1'b0));
    send_point(mk_point(0, 1, 32767, 32767, 1'b1));
  endtask

  task automatic test_origin_settings();
    write_origin(CFG_ORIGIN_X, 16'sh8000);
    write_origin(CFG_ORIGIN_Y, 16'sh7fff);
    send_mapped_set(5);
    for (int i = 0; i < 4; i++) send_point(rand_point(i == 3));
    write_origin(CFG_ORIGIN_X, 16'sh7fff);
    write_origin(CFG_ORIGIN_Y, 16'sh8000);
    send_mapped_set(4);
    write_origin(CFG_ORIGIN_X, 16'sd320);
    write_origin(CFG_ORIGIN_Y, -16'sd160);
    send_mapped_set(6);
  endtask

  // More points than the accumulators take; the last one is dropped too
  task automatic test_point_overflow();
    calm = 1'b1;
    for (int i = 0; i < MAX_PTS + 5; i++) begin
      send_point(mk_point($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                          $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                          i == MAX_PTS + 4));
    end
    calm = 1'b0;
    send_mapped_set(3);
  endtask

  task automatic test_random_sets();
    int sent, len, r;
    sent = 0;
    while (sent < 700) begin
      if ($urandom_range(9) == 0) begin
        write_origin($urandom_range(1) ? CFG_ORIGIN_Y : CFG_ORIGIN_X,
                     FIELD_W'($urandom_range(0, 1000) - 500));
      end
      calm = ($urandom_range(5) == 0);
      r = $urandom_range(99);
      if (r < 8) len = $urandom_range(1, 2);
      else if (r < 95) len = $urandom_range(3, 14);
      else len = $urandom_range(40, 100);
      if ($urandom_range(99) < 70) begin
        send_mapped_set(len);
      end else begin
        for (int i = 0; i < len; i++) send_point(rand_point(i == len - 1));
      end
      sent += len;
    end
    calm = 1'b0;
  endtask

  // Receiver back-pressure, mostly short gaps with the odd long hold-off
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(99);
    if (rx_hold > 0) begin
      rx_hold     <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && (r == 0)) begin
      rx_hold     <= $urandom_range(20, 80);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || (r < 70) || (r >= 97 ? 1'b0 : ($urandom_range(3) != 0));
    end
  end

  task automatic cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Compare every fit beat with the oldest prediction
  always @(posedge clk_i) begin
    fit_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fit_queue.size() == 0) begin
        $error("fit beat with nothing predicted");
        errors++;
      end else begin
        e = fit_queue.pop_front();
        n_fits++;
        if (e.singular) n_singular++;
        if (e.overflowed) n_ovf++;
        cmp_field("x_from_x", e.x_from_x, out_data_o.x_from_x);
        cmp_field("x_from_y", e.x_from_y, out_data_o.x_from_y);
        cmp_field("x_offset", e.x_offset, out_data_o.x_offset);
        cmp_field("y_from_x", e.y_from_x, out_data_o.y_from_x);
        cmp_field("y_from_y", e.y_from_y, out_data_o.y_from_y);
        cmp_field("y_offset", e.y_offset, out_data_o.y_offset);
        cmp_field("singular", e.singular, out_data_o.singular);
        cmp_field("overflowed", e.overflowed, out_data_o.overflowed);
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    errors = 0; n_beats = 0; n_fits = 0; n_singular = 0; n_ovf = 0;
    stall_cnt = 0;
    calm = 1'b0;
    org_x = '0;
    org_y = '0;
    clear_acc();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_singular_sets();
    test_extreme_points();
    test_origin_settings();
    test_point_overflow();
    write_origin(CFG_ORIGIN_X, '0);
    write_origin(CFG_ORIGIN_Y, '0);
    test_random_sets();
    drain();

    $display("Covered %0d point beats and %0d fits (%0d singular, %0d overflowed),",
             n_beats, n_fits, n_singular, n_ovf);
    $display("across several origin settings with idling on both sides.");
    if (errors == 0 && fit_queue.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/lsaf_pkg.sv
hw/rtl/lsaf_controller.sv
hw/rtl/lsaf_datapath.sv
hw/rtl/least_squares_affine_fit_unit.sv
verif/tb.sv
